[rtl/dmc_pkg.sv]
// shared types and constants of the direct-mapped cache tag lookup
`default_nettype none

package dmc_pkg;

   localparam int ADDR_BITS       = 32;
   localparam int MAX_INDEX_BITS  = 8;
   localparam int MAX_OFFSET_BITS = 16;
   localparam int LINE_COUNT      = 1 << MAX_INDEX_BITS;

   localparam int OB_W       = 5;
   localparam int IB_W       = 4;
   localparam int SHIFT_W    = 6;
   localparam int TAG_W      = 32;
   localparam int OFFSET_W   = 16;
   localparam int COUNT_W    = 32;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [OB_W-1:0]    OB_MAX     = OB_W'(MAX_OFFSET_BITS);
   localparam logic [IB_W-1:0]    IB_MAX     = IB_W'(MAX_INDEX_BITS);
   localparam logic [OB_W-1:0]    OB_RESET   = OB_W'(5);
   localparam logic [IB_W-1:0]    IB_RESET   = IB_W'(2);
   localparam logic [COUNT_W-1:0] COUNT_FULL = {COUNT_W{1'b1}};

   // register select, taken from paddr bit 2
   localparam logic CSR_OFFSET_BITS = 1'b0;
   localparam logic CSR_INDEX_BITS  = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SPLIT,
      ST_COMMIT
   } state_type;

   typedef struct packed {
      logic capture;
      logic split;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic out_free;
   } status_type;

endpackage

`default_nettype wire

[rtl/dmc_ctrl.sv]
// controller state machine of the tag lookup
`default_nettype none

module dmc_ctrl
   import dmc_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       in_valid,
   output logic            in_ready,
   input  wire status_type status,
   output cmd_type         cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (in_valid) begin
               state_in = ST_SPLIT;
            end
         end
         ST_SPLIT: begin
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      in_ready    = 1'b0;
      cmd.capture = 1'b0;
      cmd.split   = 1'b0;
      cmd.commit  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            in_ready    = 1'b1;
            cmd.capture = in_valid;
         end
         ST_SPLIT: begin
            cmd.split = 1'b1;
         end
         ST_COMMIT: begin
            cmd.commit = status.out_free;
         end
         default: begin
            in_ready = 1'b0;
         end
      endcase
   end

endmodule

`default_nettype wire

[rtl/dmc_datapath.sv]
// address split, tag store, valid bits, counters and result register
`default_nettype none

module dmc_datapath
   import dmc_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire cmd_type               cmd,
   output status_type                 status,
   input  wire logic [ADDR_BITS-1:0]  address,
   input  wire logic [OB_W-1:0]       offset_bits,
   input  wire logic [IB_W-1:0]       index_bits,
   output logic                       out_valid,
   input  wire logic                  out_ready,
   output logic                       out_hit,
   output logic [MAX_INDEX_BITS-1:0]  out_line,
   output logic [TAG_W-1:0]           out_tag,
   output logic [OFFSET_W-1:0]        out_offset,
   output logic [COUNT_W-1:0]         out_hits,
   output logic [COUNT_W-1:0]         out_misses
);

   logic [ADDR_BITS-1:0]      addr_ff;
   logic [OB_W-1:0]           ob;
   logic [IB_W-1:0]           ib;
   logic [SHIFT_W-1:0]        shift;
   logic [MAX_INDEX_BITS-1:0] line_in;
   logic [TAG_W-1:0]          tag_in;
   logic [OFFSET_W-1:0]       offset_in;
   logic [ADDR_BITS-1:0]      above_offset;

   logic [MAX_INDEX_BITS-1:0] line_ff;
   logic [TAG_W-1:0]          tag_ff;
   logic [OFFSET_W-1:0]       offset_ff;

   logic [TAG_W-1:0]          tag_mem [LINE_COUNT];
   logic [TAG_W-1:0]          tag_rd_ff;
   logic [LINE_COUNT-1:0]     valid_ff;

   logic                      hit;
   logic [COUNT_W-1:0]        hits_ff;
   logic [COUNT_W-1:0]        hits_in;
   logic [COUNT_W-1:0]        misses_ff;
   logic [COUNT_W-1:0]        misses_in;

   logic                      out_valid_ff;
   logic                      out_hit_ff;
   logic [MAX_INDEX_BITS-1:0] out_line_ff;
   logic [TAG_W-1:0]          out_tag_ff;
   logic [OFFSET_W-1:0]       out_offset_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         addr_ff <= address;
      end
   end

   // clamp the configured counts, then split
   always_comb begin
      ob           = (offset_bits > OB_MAX) ? OB_MAX : offset_bits;
      ib           = (index_bits > IB_MAX) ? IB_MAX : index_bits;
      shift        = SHIFT_W'(ob) + SHIFT_W'(ib);
      above_offset = addr_ff >> ob;
      offset_in    = addr_ff[OFFSET_W-1:0] & ~({OFFSET_W{1'b1}} << ob);
      line_in      = above_offset[MAX_INDEX_BITS-1:0] & ~({MAX_INDEX_BITS{1'b1}} << ib);
      tag_in       = TAG_W'(addr_ff >> shift);
   end

   always_ff @(posedge clock) begin
      if (cmd.split) begin
         line_ff   <= line_in;
         tag_ff    <= tag_in;
         offset_ff <= offset_in;
      end
   end

   // tag store: read during split, written at commit
   always_ff @(posedge clock) begin
      if (cmd.split) begin
         tag_rd_ff <= tag_mem[line_in];
      end
      if (cmd.commit) begin
         tag_mem[line_ff] <= tag_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (cmd.commit) begin
         valid_ff[line_ff] <= 1'b1;
      end
   end

   always_comb begin
      hit       = valid_ff[line_ff] && (tag_rd_ff == tag_ff);
      hits_in   = hits_ff;
      misses_in = misses_ff;
      if (hit) begin
         if (hits_ff != COUNT_FULL) begin
            hits_in = hits_ff + 1'b1;
         end
      end else begin
         if (misses_ff != COUNT_FULL) begin
            misses_in = misses_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hits_ff   <= '0;
         misses_ff <= '0;
      end else if (cmd.commit) begin
         hits_ff   <= hits_in;
         misses_ff <= misses_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         out_valid_ff <= 1'b1;
      end else if (out_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         out_hit_ff    <= hit;
         out_line_ff   <= line_ff;
         out_tag_ff    <= tag_ff;
         out_offset_ff <= offset_ff;
      end
   end

   assign status.out_free = !out_valid_ff || out_ready;

   assign out_valid  = out_valid_ff;
   assign out_hit    = out_hit_ff;
   assign out_line   = out_line_ff;
   assign out_tag    = out_tag_ff;
   assign out_offset = out_offset_ff;
   assign out_hits   = hits_ff;
   assign out_misses = misses_ff;

endmodule

`default_nettype wire

[rtl/direct_mapped_cache_tag_lookup.sv]
// top level of the direct-mapped cache tag lookup with its register port
`default_nettype none
// sequence: a beat is accepted in idle, split with its tag read in split, then compared and written in commit
// the result is registered at commit; commit waits while a held result is not yet taken
// the tag store is read in split and written in commit; a new address is taken only back in idle
// reset: synchronous active high; clears valid bits, counters and control, and loads
// offset_bits = 5 and index_bits = 2; tag store contents stay as they are

module direct_mapped_cache_tag_lookup
   import dmc_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // request beat
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [31:0]           req_tdata,    // [31:0] address
   // result beat
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [119:0]               rsp_tdata,    // [7:0] line, [39:8] tag_value,
                                                    // [55:40] block_offset,
                                                    // [87:56] hit_count, [119:88] miss_count
   output logic                       rsp_tuser,    // [0] hit
   // register port
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0]      csr_prdata,
   output logic                       csr_pready
);

   cmd_type                   cmd;
   status_type                status;

   logic [OB_W-1:0]           offset_bits_ff;
   logic [IB_W-1:0]           index_bits_ff;
   logic                      csr_wr;

   logic                      out_hit;
   logic [MAX_INDEX_BITS-1:0] out_line;
   logic [TAG_W-1:0]          out_tag;
   logic [OFFSET_W-1:0]       out_offset;
   logic [COUNT_W-1:0]        out_hits;
   logic [COUNT_W-1:0]        out_misses;

   // register port: no wait states, paddr bit 2 picks the register
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_bits_ff <= OB_RESET;
         index_bits_ff  <= IB_RESET;
      end else if (csr_wr) begin
         case (csr_paddr[2])
            CSR_OFFSET_BITS: offset_bits_ff <= csr_pwdata[OB_W-1:0];
            CSR_INDEX_BITS:  index_bits_ff  <= csr_pwdata[IB_W-1:0];
            default:         offset_bits_ff <= offset_bits_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2])
         CSR_OFFSET_BITS: csr_prdata = CSR_DATA_W'(offset_bits_ff);
         CSR_INDEX_BITS:  csr_prdata = CSR_DATA_W'(index_bits_ff);
         default:         csr_prdata = '0;
      endcase
   end

   // controller sequences accept, split and commit
   dmc_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .status   (status),
      .cmd      (cmd)
   );

   // datapath holds tag store, valid bits, counters and the result register
   dmc_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .address     (req_tdata),
      .offset_bits (offset_bits_ff),
      .index_bits  (index_bits_ff),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_hit     (out_hit),
      .out_line    (out_line),
      .out_tag     (out_tag),
      .out_offset  (out_offset),
      .out_hits    (out_hits),
      .out_misses  (out_misses)
   );

   assign rsp_tuser = out_hit;
   assign rsp_tdata = {out_misses, out_hits, out_offset, out_tag, out_line};

endmodule

`default_nettype wire
